// File: rtl/seven_segment_frame_encoder_unit_defines.svh
// Assertion helpers used by the frame sequencer RTL.
// Every check samples on clk and is disabled while arst_n is low.
`ifndef SEVEN_SEGMENT_FRAME_ENCODER_UNIT_DEFINES_SVH
`define SEVEN_SEGMENT_FRAME_ENCODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/fse_pkg.sv
package fse_pkg;

	localparam logic [15:0] BIG_LIMIT  = 16'd9999;
	localparam logic [15:0] DIV10_MULT = 16'd52429;
	localparam int unsigned DIV10_SHIFT = 19;

	localparam logic       REQ_NUMBER = 1'b0;
	localparam logic       REQ_LIGHT  = 1'b1;

	localparam logic [2:0] FRAME_TRAIL = 3'd4;
	localparam logic [2:0] FRAME_LAST_LIGHT = 3'd3;

	localparam logic [7:0] SEL_BYTE [4] = '{8'hf1, 8'hf2, 8'hf4, 8'hf8};
	localparam logic [7:0] WORD_PAT [4] = '{8'ha1, 8'h86, 8'h88, 8'ha1};
	localparam logic [7:0] LIGHT_PAT [4] = '{8'haf, 8'hc0, 8'h82, 8'h99};

	// One request as it leaves the digit pipeline: four ready segment patterns.
	typedef struct packed {
		logic            req_type;
		logic [3:0][7:0] pat;
	} item_t;

	// Active-low segment pattern of one decimal digit.
	function automatic logic [7:0] digit_pat(input logic [3:0] d);
		logic [7:0] p;
		unique case (d)
			4'd0: p = 8'hc0;
			4'd1: p = 8'hf9;
			4'd2: p = 8'ha4;
			4'd3: p = 8'hb0;
			4'd4: p = 8'h99;
			4'd5: p = 8'h92;
			4'd6: p = 8'h82;
			4'd7: p = 8'hf8;
			4'd8: p = 8'h80;
			4'd9: p = 8'h90;
			default: p = 8'hff;
		endcase
		return p;
	endfunction

	// Quotient by ten through a reciprocal multiply, exact for any 16-bit value.
	function automatic logic [12:0] div10(input logic [15:0] v);
		logic [31:0] prod;
		prod = {16'h0000, v} * {16'h0000, DIV10_MULT};
		return prod[DIV10_SHIFT +: 13];
	endfunction

	// Low decimal digit, given the value and its quotient by ten.
	function automatic logic [3:0] rem10(input logic [15:0] v, input logic [12:0] q);
		logic [15:0] tenq;
		logic [15:0] r;
		tenq = {q, 3'b000} + {2'b00, q, 1'b0};
		r = v - tenq;
		return r[3:0];
	endfunction

endpackage

// File: rtl/fse_digit_pipe.sv
module fse_digit_pipe (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          req_type,
	input  logic [15:0]   number,
	input  logic [7:0]    lights,
	input  logic          out_ready,
	output logic          out_valid,
	output fse_pkg::item_t out_item
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic        req_s1, req_s2, req_s3;
	logic        big_s1, big_s2, big_s3;
	logic [7:0]  lt_s1, lt_s2, lt_s3;
	logic [15:0] num_s1;
	logic [12:0] q_s2;
	logic [9:0]  q_s3;
	logic [3:0]  d0_s2, d0_s3, d1_s3;
	fse_pkg::item_t item_s4;

	logic [12:0] q1, q2, q3;
	logic [3:0]  d1, d2;
	fse_pkg::item_t item_c;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// quotient stages: each strips one decimal digit
	assign q1 = fse_pkg::div10(num_s1);
	assign q2 = fse_pkg::div10({3'b000, q_s2});
	assign q3 = fse_pkg::div10({6'b000000, q_s3});
	assign d1 = fse_pkg::rem10({3'b000, q_s2}, q2);
	assign d2 = fse_pkg::rem10({6'b000000, q_s3}, q3);

	always_comb begin
		item_c.req_type = req_s3;
		for (int k = 0; k < 4; k++) begin
			item_c.pat[k] = fse_pkg::LIGHT_PAT[lt_s3[2*k +: 2]];
		end
		if (req_s3 == fse_pkg::REQ_NUMBER) begin
			if (big_s3) begin
				for (int k = 0; k < 4; k++) begin
					item_c.pat[k] = fse_pkg::WORD_PAT[3-k];
				end
			end else begin
				item_c.pat[0] = fse_pkg::digit_pat(d0_s3);
				item_c.pat[1] = fse_pkg::digit_pat(d1_s3);
				item_c.pat[2] = fse_pkg::digit_pat(d2);
				item_c.pat[3] = fse_pkg::digit_pat(q3[3:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			req_s1 <= req_type;
			num_s1 <= number;
			lt_s1  <= lights;
			big_s1 <= (number >= fse_pkg::BIG_LIMIT);
		end
		if (rdy2) begin
			req_s2 <= req_s1;
			lt_s2  <= lt_s1;
			big_s2 <= big_s1;
			q_s2   <= q1;
			d0_s2  <= fse_pkg::rem10(num_s1, q1);
		end
		if (rdy3) begin
			req_s3 <= req_s2;
			lt_s3  <= lt_s2;
			big_s3 <= big_s2;
			q_s3   <= q2[9:0];
			d0_s3  <= d0_s2;
			d1_s3  <= d1;
		end
		if (rdy4) begin
			item_s4 <= item_c;
		end
	end

	assign out_valid = v_s4;
	assign out_item  = item_s4;

endmodule

// File: rtl/fse_frame_seq.sv
`include "seven_segment_frame_encoder_unit_defines.svh"

module fse_frame_seq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  fse_pkg::item_t item,
	output logic           strobe,
	output logic [7:0]     first_byte,
	output logic [7:0]     second_byte,
	output logic           two_bytes,
	output logic           last
);

	logic            act_q;
	logic [2:0]      cnt_q;
	logic            kind_q;
	logic [3:0][7:0] pat_q;
	logic            strobe_q;
	logic [7:0]      fb_q, sb_q;
	logic            two_q, last_q;

	logic       last_frame, load;
	logic [7:0] fb_c, sb_c;
	logic       two_c;
	logic [1:0] idx;

	assign idx = cnt_q[1:0];
	assign last_frame = act_q && ((kind_q == fse_pkg::REQ_LIGHT) ?
		(cnt_q == fse_pkg::FRAME_LAST_LIGHT) : (cnt_q == fse_pkg::FRAME_TRAIL));
	assign item_ready = !act_q || last_frame;
	assign load = item_valid && item_ready;

	always_comb begin
		fb_c  = pat_q[idx];
		two_c = 1'b1;
		if (kind_q == fse_pkg::REQ_LIGHT) begin
			sb_c = fse_pkg::SEL_BYTE[idx];
		end else begin
			sb_c = fse_pkg::SEL_BYTE[2'd3 - idx];
			if (cnt_q == fse_pkg::FRAME_TRAIL) begin
				fb_c  = 8'h00;
				sb_c  = 8'h00;
				two_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			cnt_q    <= 3'd0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= act_q;
			if (load) begin
				act_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (last_frame) begin
				act_q <= 1'b0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= item.req_type;
			pat_q  <= item.pat;
		end
		fb_q   <= fb_c;
		sb_q   <= sb_c;
		two_q  <= two_c;
		last_q <= last_frame;
	end

	assign strobe      = strobe_q;
	assign first_byte  = fb_q;
	assign second_byte = sb_q;
	assign two_bytes   = two_q;
	assign last        = last_q;

	`FSE_ASSERT_NEXT(a_load_starts, load, act_q && (cnt_q == 3'd0), "load did not restart frames")
	`FSE_ASSERT_NOW(a_light_len, act_q && (kind_q == fse_pkg::REQ_LIGHT), cnt_q <= 3'd3, "light overrun")
	`FSE_ASSERT_NOW(a_num_len, act_q, cnt_q <= fse_pkg::FRAME_TRAIL, "number frame count overrun")
	`FSE_ASSERT_NOW(a_trail_last, strobe_q && !two_q, last_q, "one-byte frame not last")
	`FSE_ASSERT_NEXT(a_end_idle, last_frame && !load, !act_q, "sequencer ran past last frame")

endmodule

// File: rtl/seven_segment_frame_encoder_unit.sv
// Path: a taken start crosses the pipeline stages, the sequencer's frame count and its output registers.
// Throughput: a request's frames follow one per cycle; a number request gives five, a light request four;
// that single sequencer sets the rate; the digit pipeline takes a request every cycle it is not stalled.
// Busy is high while all four pipeline stages hold requests and the sequencer is short of its final frame.
// Reset: arst_n low clears all valid bits and the strobe at once; no frame is in flight after it.
// The receiver cannot stall: each frame sits on the result ports for exactly one cycle.
module seven_segment_frame_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [15:0] number,
	input  logic [1:0]  light_zero,
	input  logic [1:0]  light_one,
	input  logic [1:0]  light_two,
	input  logic [1:0]  light_three,
	output logic        strobe,
	output logic [7:0]  first_byte,
	output logic [7:0]  second_byte,
	output logic        two_bytes,
	output logic        last
);

	// One request beat moves from the command port into the digit pipeline
	// whenever start is high and the first stage can advance.
	logic           in_ready;
	logic           item_valid;
	logic           item_ready;
	fse_pkg::item_t item;

	assign busy = !in_ready;

	// Digit pipeline: capture and range check, then three divide-by-ten stages
	// that peel off decimal digits, the last one also resolving segment patterns.
	// Light modes ride along and are looked up in the final stage.
	fse_digit_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.number    (number),
		.lights    ({light_three, light_two, light_one, light_zero}),
		.out_ready (item_ready),
		.out_valid (item_valid),
		.out_item  (item)
	);

	// Frame sequencer: hold one request and advance one frame per cycle,
	// reloading on the cycle of the final frame so requests run back to back.
	fse_frame_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.strobe      (strobe),
		.first_byte  (first_byte),
		.second_byte (second_byte),
		.two_bytes   (two_bytes),
		.last        (last)
	);

endmodule
